>>> hdl/separable_box_blur_3x3_core_defines.svh
// Assertion macros shared by the separable box blur checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SEPARABLE_BOX_BLUR_3X3_CORE_DEFINES_SVH
`define SEPARABLE_BOX_BLUR_3X3_CORE_DEFINES_SVH

// Same-cycle implication, masked while reset is low.
`define SBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is low.
`define SBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks what reset leaves behind on the cycle after it is sampled.
`define SBB_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

>>> hdl/sbb_pkg.sv
// Shared widths, register codes and the 3-tap mean for the separable box blur.
// No dependencies; used by the core and by its checker.
`timescale 1ns / 1ps
`default_nettype none

package sbb_pkg;

  localparam int PIX_W      = 16;
  localparam int OUT_COL_W  = 11;
  localparam int ROW_W      = 16;
  localparam int FW_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_DIM    = 3;

  localparam logic [FW_W-1:0]  FW_RESET  = 12'd2048;
  localparam logic [ROW_W-1:0] FH_RESET  = 16'd1;
  // 1/3 in unsigned Q0.16, truncated
  localparam logic [14:0]      THIRD_Q16 = 15'd21845;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } sbb_cfg_idx_t;

  // ((a + b + c) * 21845) >> 16; the result always fits in 16 bits
  function automatic logic [PIX_W-1:0] mean3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
    logic [17:0] sum;
    logic [32:0] prod;
    sum  = {2'b00, a} + {2'b00, b} + {2'b00, c};
    prod = {15'd0, sum} * {18'd0, THIRD_Q16};
    return prod[31:16];
  endfunction

endpackage

`default_nettype wire

>>> hdl/separable_box_blur_3x3_core.sv
// Separable 3x3 box blur core: line buffer, column sequencer and output register.
// Depends on sbb_pkg for widths, register codes and the mean3 function.
`timescale 1ns / 1ps
`default_nettype none

// Streaming 3x3 separable box blur over unsigned Q0.16 luma in raster order. Each
// input word past column 0 completes the horizontal mean of the previous column; the
// vertical mean of that column then comes from a line buffer of MAX_WIDTH x 32 bits
// (one read and one write port) holding the horizontal results of the two rows
// above. Results lag by one row and one pixel and carry their own column and row;
// row 0 gives none, the last row gives two per column (rows r-1 and r), the first
// and last row skip the vertical mean, the first and last column the horizontal one.
// Frames under 3 wide or 3 tall pass every pixel straight through. Rate: one input
// word per clock in steady state while out_ready is high. The last word of a row
// completes two columns and holds in_ready low until its second job is issued; on
// the last row each column yields two results through the single output register,
// so a word waits in stage 0 while stage 1 sends both results. Results pass stage 0,
// stage 1 and the output register. Writing either configuration register restarts
// the frame at row 0, column 0; write only while idle. The line buffer needs no
// clearing pass: every entry is written in a frame before it is used.
module separable_box_blur_3x3_core #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sbb_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sbb_pkg::PIX_W-1:0]     out_pixel_out,
  output logic [sbb_pkg::OUT_COL_W-1:0] out_col,
  output logic [sbb_pkg::ROW_W-1:0]     out_row,
  output logic                          out_last_of_run,
  input  logic                          cfg_we,
  input  logic [sbb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sbb_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers and derived frame geometry
  // ---------------------------------------------------------------------------
  logic [FW_W-1:0]   frame_width_r;
  logic [ROW_W-1:0]  frame_height_r;
  logic              cfg_hit;
  logic [WCNT_W-1:0] w_eff;
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic              bypass;

  // A write to a known register also restarts the frame.
  assign cfg_hit = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[ROW_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Width of zero acts as one; width beyond the line buffer saturates.
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WCNT_W'(1);
    end else if (frame_width_r > MAX_WIDTH) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(frame_width_r);
    end
  end

  assign wm1    = COL_W'(w_eff - WCNT_W'(1));
  assign hm1    = (frame_height_r == '0) ? '0 : frame_height_r - ROW_W'(1);
  assign bypass = (w_eff < MIN_DIM) || (frame_height_r < MIN_DIM);

  // ---------------------------------------------------------------------------
  // Input side: raster position and the last two raw samples
  // ---------------------------------------------------------------------------
  logic             in_fire;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [PIX_W-1:0] raw1_r;
  logic [PIX_W-1:0] raw2_r;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      col_r  <= '0;
      row_r  <= '0;
      raw1_r <= '0;
      raw2_r <= '0;
    end else if (in_fire) begin
      if (col_r == wm1) begin
        col_r <= '0;
        row_r <= (row_r == hm1) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
      if (!bypass) begin
        raw2_r <= raw1_r;
        raw1_r <= in_pixel_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register; issues up to two column jobs per word
  // ---------------------------------------------------------------------------
  logic             s0_valid_r;
  logic             s0_sub_r;      // first job already issued
  logic [PIX_W-1:0] s0_px_r;
  logic [PIX_W-1:0] s0_p1_r;
  logic [PIX_W-1:0] s0_p2_r;
  logic [COL_W-1:0] s0_col_r;
  logic [ROW_W-1:0] s0_row_r;
  logic             s0_pass_r;
  logic             s0_lastcol_r;

  logic             s0_has_job;
  logic             s0_split;
  logic             s0_retire;
  logic             issue;
  logic [COL_W-1:0] job_x;
  logic [PIX_W-1:0] job_h;
  logic             job_last;
  logic             s1_free;

  // Pass-through words and second jobs carry the word's own column and pixel.
  assign s0_has_job = s0_pass_r || s0_sub_r || (s0_col_r != '0);
  assign s0_split   = !s0_sub_r && !s0_pass_r && (s0_col_r != '0) && s0_lastcol_r;
  assign issue      = s0_valid_r && s0_has_job && s1_free;
  assign s0_retire  = s0_valid_r && (!s0_has_job || (s1_free && !s0_split));
  assign in_ready   = !s0_valid_r || s0_retire;

  always_comb begin
    if (s0_pass_r || s0_sub_r) begin
      job_x    = s0_col_r;
      job_h    = s0_px_r;
      job_last = 1'b1;
    end else begin
      // Horizontal mean of the previous column; the first column is copied.
      job_x    = s0_col_r - COL_W'(1);
      job_h    = (s0_col_r == COL_W'(1)) ? s0_p1_r : mean3(s0_p2_r, s0_p1_r, s0_px_r);
      job_last = !s0_lastcol_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s0_sub_r   <= 1'b0;
    end else if (in_fire) begin
      s0_valid_r <= 1'b1;
      s0_sub_r   <= 1'b0;
    end else if (s0_retire) begin
      s0_valid_r <= 1'b0;
      s0_sub_r   <= 1'b0;
    end else if (issue && s0_split) begin
      s0_sub_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_px_r      <= in_pixel_in;
      s0_p1_r      <= raw1_r;
      s0_p2_r      <= raw2_r;
      s0_col_r     <= col_r;
      s0_row_r     <= row_r;
      s0_pass_r    <= bypass;
      s0_lastcol_r <= (col_r == wm1);
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffer: {row r-2, row r-1} horizontal results per column
  // ---------------------------------------------------------------------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic [PIX_W-1:0]   rd_older;
  logic [PIX_W-1:0]   rd_newer;

  logic             s1_valid_r;
  logic             s1_phase_r;    // first of two results already sent
  logic [COL_W-1:0] s1_x_r;
  logic [PIX_W-1:0] s1_h_r;
  logic [ROW_W-1:0] s1_row_r;
  logic             s1_pass_r;
  logic             s1_last_r;
  logic             s1_done;

  assign rd_older = rd_data_r[2*PIX_W-1:PIX_W];
  assign rd_newer = rd_data_r[PIX_W-1:0];

  // Consecutive jobs never share a column, so read and write never collide.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= line_mem[job_x];
    end
    if (s1_done && !s1_pass_r) begin
      line_mem[s1_x_r] <= {rd_newer, s1_h_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: vertical mean and result sequencing
  // ---------------------------------------------------------------------------
  logic             row_nz;
  logic             row_one;
  logic             row_last;
  logic [PIX_W-1:0] vmean;
  logic             s1_emit;
  logic             s1_two;
  logic             out_free;
  logic             emit_fire;
  logic [PIX_W-1:0] res_pix;
  logic [ROW_W-1:0] res_row;
  logic             res_last;
  logic             out_valid_r;

  assign row_nz   = (s1_row_r != '0);
  assign row_one  = (s1_row_r == ROW_W'(1));
  assign row_last = (s1_row_r == hm1);
  // Input row 1 gives output row 0, the first row, copied.
  assign vmean    = row_one ? rd_newer : mean3(rd_older, rd_newer, s1_h_r);

  assign out_free  = !out_valid_r || out_ready;
  assign s1_emit   = s1_valid_r && (s1_pass_r || s1_phase_r || row_nz);
  assign s1_two    = !s1_pass_r && !s1_phase_r && row_last;
  assign emit_fire = s1_emit && out_free;
  assign s1_done   = s1_valid_r && (!s1_emit || out_free) && !s1_two;
  assign s1_free   = !s1_valid_r || s1_done;

  always_comb begin
    if (s1_pass_r || s1_phase_r) begin
      // Pass-through pixel, or the last row copied after its vertical result.
      res_pix  = s1_h_r;
      res_row  = s1_row_r;
      res_last = s1_last_r;
    end else begin
      res_pix  = vmean;
      res_row  = s1_row_r - ROW_W'(1);
      res_last = s1_last_r && !row_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_phase_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= issue;
      s1_phase_r <= 1'b0;
    end else if (emit_fire && s1_two) begin
      s1_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && s1_free) begin
      s1_x_r    <= job_x;
      s1_h_r    <= job_h;
      s1_row_r  <= s0_row_r;
      s1_pass_r <= s0_pass_r;
      s1_last_r <= job_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a result while the sink stalls
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]     out_pix_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [ROW_W-1:0]     out_row_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_pix_r  <= res_pix;
      out_col_r  <= OUT_COL_W'(s1_x_r);
      out_row_r  <= res_row;
      out_last_r <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = out_pix_r;
  assign out_col         = out_col_r;
  assign out_row         = out_row_r;
  assign out_last_of_run = out_last_r;

endmodule

`default_nettype wire

>>> hdl/sbb_checker.sv
// Port-level checks for the separable box blur core, bound to its top level.
// Depends on sbb_pkg and separable_box_blur_3x3_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "separable_box_blur_3x3_core_defines.svh"

module sbb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sbb_pkg::PIX_W-1:0]     out_pixel_out,
  input logic [sbb_pkg::OUT_COL_W-1:0] out_col,
  input logic [sbb_pkg::ROW_W-1:0]     out_row,
  input logic                          out_last_of_run
);
  import sbb_pkg::*;

  // Reset empties the output register.
  `SBB_ASSERT_RST(a_rst_out_empty, !out_valid, "out_valid high after reset")

  // A stalled result holds.
  `SBB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pixel_out) && $stable(out_col) && $stable(out_row) && $stable(out_last_of_run), "stalled result changed")

  // A run of results from one word comes without gaps.
  `SBB_ASSERT_NXT(a_run_gapless, out_valid && out_ready && !out_last_of_run, out_valid, "gap inside a result run")

endmodule

bind separable_box_blur_3x3_core sbb_checker u_sbb_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for separable_box_blur_3x3_core: streams luma frames in raster order
// and compares every blurred word with an in-bench line-buffer predictor.
// Depends on sbb_pkg (widths, register codes) and the core itself.

module tb_top;

  localparam int CLK_HALF     = 6;     // 12 ns period
  localparam int RST_CYCLES   = 3;
  localparam int DRAIN_CYCLES = 16;    // output lags input by the stage 0, stage 1 and output registers
  localparam int STALL_LIMIT  = 3000;  // cycles with no word moved before giving up
  localparam int RANDOM_WORDS = 100;
  localparam int WIDE_WORDS   = 12;
  localparam int HOLD_OFF     = 300;   // long receiver hold-off for the pressure test
  localparam int MAX_REPORTS  = 100;
  localparam int LINE_MAX     = 2048;
  localparam longint unsigned THIRD_Q16 = 21845;  // 1/3 in Q0.16, truncated

  localparam logic [sbb_pkg::PIX_W-1:0]     PIX_ZERO = '0;
  localparam logic [sbb_pkg::PIX_W-1:0]     PIX_FULL = '1;
  // indexes past the register list; writes there must be ignored
  localparam logic [sbb_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd2;
  localparam logic [sbb_pkg::CFG_IDX_W-1:0] CFG_IDX_NONE  = 2'd3;

  typedef struct packed {
    logic [sbb_pkg::PIX_W-1:0]     pix;
    logic [sbb_pkg::OUT_COL_W-1:0] col;
    logic [sbb_pkg::ROW_W-1:0]     row;
    logic                          last;
  } blurred_px_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_valid   = 1'b0;
  logic                            in_ready;
  logic [sbb_pkg::PIX_W-1:0]       in_pixel_in = '0;
  logic                            out_valid;
  logic                            out_ready  = 1'b0;
  logic [sbb_pkg::PIX_W-1:0]       out_pixel_out;
  logic [sbb_pkg::OUT_COL_W-1:0]   out_col;
  logic [sbb_pkg::ROW_W-1:0]       out_row;
  logic                            out_last_of_run;
  logic                            cfg_we     = 1'b0;
  logic [sbb_pkg::CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [sbb_pkg::CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // idling controls, flipped by the tests
  bit in_gaps_on    = 1'b1;
  bit out_stalls_on = 1'b1;
  int hold_request  = 0;   // picked up by the receiver, which counts it down itself
  int err_count     = 0;

  separable_box_blur_3x3_core #(.MAX_WIDTH(LINE_MAX)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_out   (out_pixel_out),
    .out_col         (out_col),
    .out_row         (out_row),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own line buffers, raw taps, position and register copies.
  // ---------------------------------------------------------------------------
  logic [sbb_pkg::PIX_W-1:0] hsum_older [LINE_MAX];  // horizontal means of row r-2
  logic [sbb_pkg::PIX_W-1:0] hsum_newer [LINE_MAX];  // horizontal means of row r-1
  logic [sbb_pkg::PIX_W-1:0] raw_last, raw_last2;
  int unsigned               next_col, next_row;
  logic [sbb_pkg::FW_W-1:0]  width_reg;
  logic [sbb_pkg::ROW_W-1:0] height_reg;
  int unsigned               step_results;

  blurred_px_t blurred_due [$];  // blurred words still to come, oldest first

  function automatic logic [sbb_pkg::PIX_W-1:0] third_of_sum(
    input logic [sbb_pkg::PIX_W-1:0] a,
    input logic [sbb_pkg::PIX_W-1:0] b,
    input logic [sbb_pkg::PIX_W-1:0] c);
    longint unsigned s;
    longint unsigned p;
    s = a;
    s = s + b + c;
    p = (s * THIRD_Q16) >> 16;
    return p[sbb_pkg::PIX_W-1:0];
  endfunction

  task automatic restart_position;
    next_col  = 0;
    next_row  = 0;
    raw_last  = '0;
    raw_last2 = '0;
  endtask

  task automatic emit(input logic [sbb_pkg::PIX_W-1:0] px, input logic [31:0] col,
                      input logic [31:0] row);
    blurred_px_t e;
    e.pix  = px;
    e.col  = col[sbb_pkg::OUT_COL_W-1:0];
    e.row  = row[sbb_pkg::ROW_W-1:0];
    e.last = 1'b0;
    blurred_due.push_back(e);
    step_results++;
  endtask

  // Column x of row r now has its horizontal mean hv: emit what that completes.
  task automatic finish_column(input int unsigned x, input logic [sbb_pkg::PIX_W-1:0] hv,
                               input int unsigned r, input int unsigned h);
    if (r != 0) begin
      // first row of the frame skips the vertical mean; interior rows take it
      if (r == 1)
        emit(hsum_newer[x], x, r - 1);
      else
        emit(third_of_sum(hsum_older[x], hsum_newer[x], hv), x, r - 1);
      // last row flushes its own horizontal result as well
      if (r == h - 1)
        emit(hv, x, r);
      hsum_older[x] = hsum_newer[x];
    end
    hsum_newer[x] = hv;
  endtask

  task automatic predict_blur(input logic [sbb_pkg::PIX_W-1:0] px);
    int unsigned w, h, c, r;
    blurred_px_t tail;
    // zero sizes count as one; widths past the line buffer saturate
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > LINE_MAX)
      w = LINE_MAX;
    h = (height_reg == 0) ? 1 : height_reg;
    if (next_col >= w)
      next_col = 0;
    if (next_row >= h)
      next_row = 0;
    c = next_col;
    r = next_row;
    step_results = 0;

    if (w < 3 || h < 3) begin
      emit(px, c, r);  // too narrow or too short: pass straight through
    end else begin
      // this word completes column c-1; the first column is copied as it is
      if (c == 1)
        finish_column(0, raw_last, r, h);
      else if (c >= 2)
        finish_column(c - 1, third_of_sum(raw_last2, raw_last, px), r, h);
      // the last word of a row also completes the last column, unaltered
      if (c == w - 1)
        finish_column(c, px, r, h);
      raw_last2 = raw_last;
      raw_last  = px;
    end

    if (step_results > 0) begin
      tail = blurred_due.pop_back();
      tail.last = 1'b1;
      blurred_due.push_back(tail);
    end

    // advance the raster position, wrapping rows and frames
    next_col = c + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = r + 1;
      if (next_row >= h)
        next_row = 0;
    end
  endtask

  task automatic model_reg_write(input logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [sbb_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sbb_pkg::CFG_FRAME_WIDTH: begin
        width_reg = data[sbb_pkg::FW_W-1:0];
        restart_position();
      end
      sbb_pkg::CFG_FRAME_HEIGHT: begin
        height_reg = data[sbb_pkg::ROW_W-1:0];
        restart_position();
      end
      default: ;  // unknown index: no effect at all
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly short idles, now and then a long one.
  function automatic int stall_len();
    if ($urandom_range(99) < 90)
      return $urandom_range(1, 3);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [sbb_pkg::PIX_W-1:0] rand_pixel();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10)
      return PIX_ZERO;
    if (pick < 20)
      return PIX_FULL;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one word at the falling edge, hold it until accepted, then predict.
  // Valid stays high after acceptance; the next call replaces the word or drops valid for a gap, and settle() drops it.
  task automatic send_word(input logic [sbb_pkg::PIX_W-1:0] px);
    int gap;
    gap = (in_gaps_on && $urandom_range(99) < 30) ? stall_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (!in_ready);
    predict_blur(px);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline run dry.
  task automatic settle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (blurred_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers change only on an idle block.
  task automatic write_reg(input logic [sbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sbb_pkg::CFG_DATA_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_reg_write(idx, data);
  endtask

  task automatic set_frame(input logic [sbb_pkg::CFG_DATA_W-1:0] w,
                           input logic [sbb_pkg::CFG_DATA_W-1:0] h);
    write_reg(sbb_pkg::CFG_FRAME_WIDTH, w);
    write_reg(sbb_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset leaves a 2048 x 1 frame: every word passes through unchanged.
  task automatic test_reset_passthrough;
    send_word(PIX_ZERO);
    send_word(PIX_FULL);
    send_word(16'h8000);
    send_word(16'h0001);
  endtask

  // Smallest frame that blurs, fed with extremes to reach the largest sums.
  task automatic test_min_frame;
    set_frame(3, 3);
    repeat (6) send_word(PIX_FULL);
    send_word(PIX_ZERO);
    send_word(PIX_FULL);
    send_word(PIX_ZERO);
  endtask

  // Zero sizes, sizes under three, masked width bits and ignored indexes.
  task automatic test_degenerate_sizes;
    write_reg(sbb_pkg::CFG_FRAME_WIDTH, 16'h0000);   // width zero acts as one
    send_word(16'h1234);
    send_word(16'hFEDC);
    write_reg(sbb_pkg::CFG_FRAME_WIDTH, 16'hF004);   // bits above the field drop
    write_reg(sbb_pkg::CFG_FRAME_HEIGHT, 16'h0000);  // height zero acts as one
    send_word(16'h5555);
    send_word(16'hAAAA);
    write_reg(sbb_pkg::CFG_FRAME_HEIGHT, 16'h0002);
    send_word(16'h00FF);
    send_word(16'hFF00);
    // out-of-range index: position must carry on where it was
    write_reg(CFG_IDX_SPARE, 16'h0003);
    write_reg(CFG_IDX_NONE, 16'hFFFF);
    send_word(16'h7FFF);
  endtask

  // Width past the line buffer saturates; offer the start of a full-width row.
  task automatic test_wide_frame;
    set_frame(16'h0FFF, 3);
    repeat (WIDE_WORDS) send_word(rand_pixel());
  endtask

  // Hold the receiver off while the sender keeps offering words back to back.
  task automatic test_back_pressure;
    set_frame(5, 4);
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    @(posedge clk);
    hold_request = HOLD_OFF;
    repeat (40) send_word(rand_pixel());
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Random sizes; mostly whole frames, sometimes cut short.
  task automatic test_random_frames;
    int unsigned w, h, w_eff, h_eff, n, sent;
    int pick;
    logic [sbb_pkg::CFG_DATA_W-1:0] wdata;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 75)
        w = $urandom_range(3, 8);
      else if (pick < 87)
        w = $urandom_range(1, 2);
      else if (pick < 92)
        w = 0;
      else
        w = $urandom_range(9, 24);
      pick = $urandom_range(99);
      if (pick < 70)
        h = $urandom_range(3, 5);
      else if (pick < 82)
        h = $urandom_range(0, 2);
      else if (pick < 90)
        h = 65535;
      else
        h = $urandom_range(6, 65534);
      w_eff = (w == 0) ? 1 : w;
      h_eff = (h == 0) ? 1 : h;
      if (h_eff <= 5 && $urandom_range(99) < 80)
        n = w_eff * h_eff * $urandom_range(1, 2);
      else
        n = $urandom_range(1, 3 * w_eff + 2);

      wdata = 16'(w);
      wdata[sbb_pkg::CFG_DATA_W-1:sbb_pkg::FW_W] = 4'($urandom_range(15));  // ignored bits
      if ($urandom_range(1)) begin
        write_reg(sbb_pkg::CFG_FRAME_WIDTH, wdata);
        write_reg(sbb_pkg::CFG_FRAME_HEIGHT, 16'(h));
      end else begin
        write_reg(sbb_pkg::CFG_FRAME_HEIGHT, 16'(h));
        write_reg(sbb_pkg::CFG_FRAME_WIDTH, wdata);
      end
      in_gaps_on    = ($urandom_range(99) < 80);
      out_stalls_on = ($urandom_range(99) < 80);
      repeat (n) send_word(rand_pixel());
      sent += n;
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at the falling edge, plus any long hold requested.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (out_stalls_on && $urandom_range(99) < 25) begin
        out_ready  <= 1'b0;
        stall_left = stall_len() - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: each accepted word against the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_blurred
    blurred_px_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blurred_due.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual pixel %0d col %0d row %0d",
                   $time, out_pixel_out, out_col, out_row);
      end else begin
        want = blurred_due.pop_front();
        if (out_pixel_out !== want.pix)
          report_mismatch("pixel_out", want.pix, out_pixel_out);
        if (out_col !== want.col)
          report_mismatch("out_col", want.col, out_col);
        if (out_row !== want.row)
          report_mismatch("out_row", want.row, out_row);
        if (out_last_of_run !== want.last)
          report_mismatch("last_of_run", want.last, out_last_of_run);
      end
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: timeout, no word moved for %0d cycles, %0d words still due",
             $time, STALL_LIMIT, blurred_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    width_reg  = sbb_pkg::FW_RESET;
    height_reg = sbb_pkg::FH_RESET;
    restart_position();
    foreach (hsum_older[i]) begin
      hsum_older[i] = '0;
      hsum_newer[i] = '0;
    end

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_passthrough();
    test_min_frame();
    test_degenerate_sizes();
    test_wide_frame();
    test_back_pressure();
    test_random_frames();
    settle();

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sbb_pkg.sv
hdl/separable_box_blur_3x3_core.sv
hdl/sbb_checker.sv
sim/tb_top.sv
